[rtl/core/cell_quality_qualifier_unit_macros.svh]
// Assertion macros used by the cell quality qualifier checker
`ifndef CELL_QUALITY_QUALIFIER_UNIT_MACROS_SVH
`define CELL_QUALITY_QUALIFIER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define CQQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define CQQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/cqq_pkg.sv]
// Types and constants shared by the cell quality qualifier modules
package cqq_pkg;

    localparam int DATA_W    = 16;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        ST_MEASURING     = 3'd0,
        ST_NOT_BROKEN_IN = 3'd1,
        ST_GOOD          = 3'd2,
        ST_BAD           = 3'd3,
        ST_TIMEOUT       = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MEMBRANE_LIMIT = 3'd0,
        REG_ACCESS_LIMIT   = 3'd1,
        REG_HOLDING_LIMIT  = 3'd2,
        REG_BALLS_NEEDED   = 3'd3,
        REG_STRIKE_LIMIT   = 3'd4,
        REG_MAX_SAMPLES    = 3'd5
    } cfg_reg_t;

    localparam logic [15:0] MEMBRANE_LIMIT_RST = 16'd5000;
    localparam logic [15:0] ACCESS_LIMIT_RST   = 16'd250;
    localparam logic [14:0] HOLDING_LIMIT_RST  = 15'd1000;
    localparam logic [3:0]  BALLS_NEEDED_RST   = 4'd3;
    localparam logic [3:0]  STRIKE_LIMIT_RST   = 4'd10;
    localparam logic [7:0]  MAX_SAMPLES_RST    = 8'd120;

    localparam logic [3:0] COUNT_MAX   = 4'd15;
    localparam logic [7:0] SAMPLES_MAX = 8'd255;

    typedef struct packed {
        logic [15:0] membrane_limit;
        logic [15:0] access_limit;
        logic [14:0] holding_limit;
        logic [3:0]  balls_needed;
        logic [3:0]  strike_limit;
        logic [7:0]  max_samples;
    } cfg_t;

    typedef struct packed {
        logic               restart;
        logic [15:0]        membrane;
        logic [15:0]        access;
        logic signed [15:0] holding;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic        passed;
        logic        evaluated;
        logic [3:0]  strike_count;
        logic [3:0]  ball_count;
        logic [7:0]  sample_count;
    } result_t;

endpackage

[rtl/core/cqq_core.sv]
// Qualification state and its combinational update for one sample beat
module cqq_core
    import cqq_pkg::*;
#(
    parameter int AVERAGE_COUNT = 3
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  item_t   item,
    input  logic    step,
    output result_t result
);

    localparam int FW = $clog2(AVERAGE_COUNT + 1);
    localparam int SW = DATA_W + $clog2(AVERAGE_COUNT);
    localparam logic [FW-1:0] FILL_FULL = FW'(AVERAGE_COUNT);
    localparam logic [SW-1:0] AVG_N     = SW'(AVERAGE_COUNT);

    logic [SW-1:0]        msum_reg, msum_next;
    logic [SW-1:0]        asum_reg, asum_next;
    logic signed [SW-1:0] csum_reg, csum_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [3:0]           strike_reg, strike_next;
    logic [3:0]           ball_reg, ball_next;
    logic [7:0]           samples_reg, samples_next;
    logic                 finished_reg, finished_next;
    status_t              status_reg, status_next;

    logic [SW-1:0] m_thresh;
    logic [SW-1:0] a_thresh;
    logic [SW-1:0] h_thresh;
    logic [SW-1:0] c_mag;
    logic          good;
    logic          evaluated;

    // limits scaled by the group size so the sums need no division
    assign m_thresh = SW'(AVG_N * SW'(cfg.membrane_limit));
    assign a_thresh = SW'(AVG_N * SW'(cfg.access_limit));
    assign h_thresh = SW'(AVG_N * SW'(cfg.holding_limit));
    assign c_mag    = csum_reg[SW-1] ? SW'(~csum_reg + SW'(1)) : SW'(csum_reg);
    assign good     = (asum_reg < a_thresh) && (c_mag < h_thresh);

    always_comb
    begin
        msum_next     = msum_reg;
        asum_next     = asum_reg;
        csum_next     = csum_reg;
        fill_next     = fill_reg;
        strike_next   = strike_reg;
        ball_next     = ball_reg;
        samples_next  = samples_reg;
        finished_next = finished_reg;
        status_next   = status_reg;
        evaluated     = 1'b0;
        if (step)
        begin
            if (item.restart)
            begin
                msum_next     = '0;
                asum_next     = '0;
                csum_next     = '0;
                fill_next     = '0;
                strike_next   = '0;
                ball_next     = '0;
                samples_next  = '0;
                finished_next = 1'b0;
                status_next   = ST_MEASURING;
            end
            else if (!finished_reg)
            begin
                if (samples_reg != SAMPLES_MAX)
                begin
                    samples_next = samples_reg + 8'd1;
                end
                if (fill_reg >= FILL_FULL)
                begin
                    evaluated = 1'b1;
                    fill_next = '0;
                    msum_next = '0;
                    asum_next = '0;
                    csum_next = '0;
                    if (msum_reg > m_thresh)
                    begin
                        finished_next = 1'b1;
                        status_next   = ST_NOT_BROKEN_IN;
                    end
                    else
                    begin
                        if (good)
                        begin
                            strike_next = '0;
                            ball_next   = (ball_reg == COUNT_MAX) ? COUNT_MAX : ball_reg + 4'd1;
                        end
                        else
                        begin
                            ball_next   = '0;
                            strike_next = (strike_reg == COUNT_MAX) ? COUNT_MAX
                                                                    : strike_reg + 4'd1;
                        end
                        if (strike_next >= cfg.strike_limit)
                        begin
                            finished_next = 1'b1;
                            status_next   = ST_BAD;
                        end
                        else if (ball_next >= cfg.balls_needed)
                        begin
                            finished_next = 1'b1;
                            status_next   = ST_GOOD;
                        end
                    end
                end
                else
                begin
                    fill_next = fill_reg + FW'(1);
                    msum_next = msum_reg + SW'(item.membrane);
                    asum_next = asum_reg + SW'(item.access);
                    csum_next = csum_reg + SW'(item.holding);
                end
                if (samples_next > cfg.max_samples)
                begin
                    finished_next = 1'b1;
                    status_next   = ST_TIMEOUT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msum_reg     <= '0;
            asum_reg     <= '0;
            csum_reg     <= '0;
            fill_reg     <= '0;
            strike_reg   <= '0;
            ball_reg     <= '0;
            samples_reg  <= '0;
            finished_reg <= 1'b0;
            status_reg   <= ST_MEASURING;
        end
        else
        begin
            msum_reg     <= msum_next;
            asum_reg     <= asum_next;
            csum_reg     <= csum_next;
            fill_reg     <= fill_next;
            strike_reg   <= strike_next;
            ball_reg     <= ball_next;
            samples_reg  <= samples_next;
            finished_reg <= finished_next;
            status_reg   <= status_next;
        end
    end

    always_comb
    begin
        result.status       = status_next;
        result.passed       = (status_next == ST_GOOD);
        result.evaluated    = evaluated;
        result.strike_count = strike_next;
        result.ball_count   = ball_next;
        result.sample_count = samples_next;
    end

endmodule

[rtl/core/cell_quality_qualifier_unit.sv]
// Top level of the cell quality qualifier: handshake, registers and pipeline
// Accepts one membrane-test sample beat per clock while the output is not
// stalled and returns one result beat per sample. An input register feeds a
// combinational state update whose result lands in an output register, so a
// new beat can enter the empty input register while a finished result waits.
// The per-beat sum and counter update sets that rate. cfg_ready is always high;
// the user writes limits only while no beat is in flight; nothing checks it.
module cell_quality_qualifier_unit
    import cqq_pkg::*;
#(
    parameter int AVERAGE_COUNT = 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 restart,
    input  logic [15:0]          membrane_resistance,
    input  logic [15:0]          access_resistance,
    input  logic signed [15:0]   holding_current,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic                 passed,
    output logic                 evaluated,
    output logic [3:0]           strike_count,
    output logic [3:0]           ball_count,
    output logic [7:0]           sample_count
);

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    in_valid_reg, in_valid_next;
    result_t result_reg;
    logic    out_valid_reg, out_valid_next;
    result_t result_next;
    logic    out_open;
    logic    step;
    logic    in_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.membrane_limit <= MEMBRANE_LIMIT_RST;
            cfg_reg.access_limit   <= ACCESS_LIMIT_RST;
            cfg_reg.holding_limit  <= HOLDING_LIMIT_RST;
            cfg_reg.balls_needed   <= BALLS_NEEDED_RST;
            cfg_reg.strike_limit   <= STRIKE_LIMIT_RST;
            cfg_reg.max_samples    <= MAX_SAMPLES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MEMBRANE_LIMIT: cfg_reg.membrane_limit <= cfg_data;
                REG_ACCESS_LIMIT:   cfg_reg.access_limit   <= cfg_data;
                REG_HOLDING_LIMIT:  cfg_reg.holding_limit  <= cfg_data[14:0];
                REG_BALLS_NEEDED:   cfg_reg.balls_needed   <= cfg_data[3:0];
                REG_STRIKE_LIMIT:   cfg_reg.strike_limit   <= cfg_data[3:0];
                REG_MAX_SAMPLES:    cfg_reg.max_samples    <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    assign out_open = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_open;
    assign in_stall = in_valid_reg && !out_open;
    assign in_take  = in_valid && !in_stall;

    assign in_valid_next  = in_take ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    assign out_valid_next = step ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.restart  <= restart;
            item_reg.membrane <= membrane_resistance;
            item_reg.access   <= access_resistance;
            item_reg.holding  <= holding_current;
        end
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    cqq_core #(
        .AVERAGE_COUNT (AVERAGE_COUNT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .item   (item_reg),
        .step   (step),
        .result (result_next)
    );

    assign out_valid    = out_valid_reg;
    assign status       = result_reg.status;
    assign passed       = result_reg.passed;
    assign evaluated    = result_reg.evaluated;
    assign strike_count = result_reg.strike_count;
    assign ball_count   = result_reg.ball_count;
    assign sample_count = result_reg.sample_count;

endmodule

[rtl/core/cqq_checker.sv]
// Port-level checker for the cell quality qualifier, bound to the top level
`include "cell_quality_qualifier_unit_macros.svh"

module cqq_checker
    import cqq_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 restart,
    input logic [15:0]          membrane_resistance,
    input logic [15:0]          access_resistance,
    input logic signed [15:0]   holding_current,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [2:0]           status,
    input logic                 passed,
    input logic                 evaluated,
    input logic [3:0]           strike_count,
    input logic [3:0]           ball_count,
    input logic [7:0]           sample_count
);

    logic [48:0] in_beat;
    logic [20:0] out_beat;
    logic        in_wait;
    logic        out_wait;
    logic        eval_beat;
    logic        passed_ok;
    logic        counts_ok;

    assign in_beat   = {restart, membrane_resistance, access_resistance, holding_current};
    assign out_beat  = {status, passed, evaluated, strike_count, ball_count, sample_count};
    assign in_wait   = in_valid && in_stall;
    assign out_wait  = out_valid && out_stall;
    assign eval_beat = out_valid && evaluated;
    assign passed_ok = passed == (status == ST_GOOD);
    assign counts_ok = strike_count == 4'd0 || ball_count == 4'd0;

    // stalled beats must hold
    `CQQ_ASSERT_NEXT(a_in_hold, clk, rst_n, in_wait, in_valid && $stable(in_beat), "input held")
    `CQQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_beat), "result held")

    `CQQ_ASSERT_NOW(a_passed_good, clk, rst_n, out_valid, passed_ok, "passed vs status")

    `CQQ_ASSERT_NOW(a_eval_samples, clk, rst_n, eval_beat, sample_count != 8'd0, "eval, no samples")

    `CQQ_ASSERT_NOW(a_counts_excl, clk, rst_n, out_valid, counts_ok, "balls and strikes both set")

endmodule

bind cell_quality_qualifier_unit cqq_checker u_cqq_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .restart             (restart),
    .membrane_resistance (membrane_resistance),
    .access_resistance   (access_resistance),
    .holding_current     (holding_current),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .status              (status),
    .passed              (passed),
    .evaluated           (evaluated),
    .strike_count        (strike_count),
    .ball_count          (ball_count),
    .sample_count        (sample_count)
);
